/* hdl/rcce_pkg.sv */
`timescale 1ns / 1ps

package rcce_pkg;

    localparam int NODE_BITS  = 8;
    localparam int DIST_BITS  = 16;
    localparam int DEM_BITS   = 16;
    localparam int VAL_BITS   = 16;
    localparam int POS_BITS   = 10;
    localparam int TOUR_LEN   = 1024;
    localparam int LOAD_BITS  = 24;
    localparam int SUM_BITS   = 32;
    localparam int FIT_BITS   = 25;
    localparam int WGT_BITS   = 16;
    localparam int PROD_BITS  = SUM_BITS + WGT_BITS;
    localparam int DEN_BITS   = PROD_BITS - 8 + 1;
    localparam int CNT_BITS   = $clog2(FIT_BITS);
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int CIDX_BITS  = 4;
    localparam int CDATA_BITS = 24;

    localparam logic [NODE_BITS-1:0]  DEPOT   = NODE_BITS'(1);
    localparam logic [FIT_BITS-1:0]   FIT_ONE = FIT_BITS'(1) << 24;
    localparam logic [LOAD_BITS-1:0]  CAP_RESET = '1;
    localparam logic [WGT_BITS-1:0]   WGT_RESET = WGT_BITS'(256);

    localparam logic [1:0] CMD_DIST   = 2'd0;
    localparam logic [1:0] CMD_DEMAND = 2'd1;
    localparam logic [1:0] CMD_NODE   = 2'd2;

    localparam logic [CIDX_BITS-1:0] REG_CAPACITY = CIDX_BITS'(0);
    localparam logic [CIDX_BITS-1:0] REG_WEIGHT   = CIDX_BITS'(1);

    typedef enum logic [1:0] {
        OP_DIST   = 2'd0,
        OP_DEMAND = 2'd1,
        OP_NODE   = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]           command;
        logic [NODE_BITS-1:0] node;
        logic [NODE_BITS-1:0] peer_node;
        logic [VAL_BITS-1:0]  entry_value;
        logic                 last_in_route;
    } t_in_item;

    typedef struct packed {
        logic [SUM_BITS-1:0] tour_cost;
        logic [SUM_BITS-1:0] overload_total;
        logic                is_feasible;
        logic [FIT_BITS-1:0] fitness_score;
        logic [POS_BITS-1:0] overload_begin;
        logic [POS_BITS-1:0] overload_finish;
    } t_out_item;

    typedef struct packed {
        t_op                  op;
        logic [NODE_BITS-1:0] node;
        logic [NODE_BITS-1:0] peer;
        logic [VAL_BITS-1:0]  value;
        logic                 last;
    } t_entry;

    typedef struct packed {
        logic [SUM_BITS-1:0] cost;
        logic [SUM_BITS-1:0] excess;
        logic [POS_BITS-1:0] vbegin;
        logic [POS_BITS-1:0] vfinish;
    } t_job;

    function automatic logic [SUM_BITS-1:0] sat_add32(input logic [SUM_BITS-1:0] a,
                                                     input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

    function automatic logic [LOAD_BITS-1:0] sat_add24(input logic [LOAD_BITS-1:0] a,
                                                      input logic [DEM_BITS-1:0] b);
        logic [LOAD_BITS:0] s;
        s = {1'b0, a} + {{(LOAD_BITS-DEM_BITS+1){1'b0}}, b};
        return s[LOAD_BITS] ? '1 : s[LOAD_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] next_pos(input logic [POS_BITS-1:0] p);
        return (p == POS_BITS'(TOUR_LEN - 1)) ? '0 : p + POS_BITS'(1);
    endfunction

endpackage

/* hdl/rcce_front.sv */
`timescale 1ns / 1ps

module rcce_front import rcce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_ent_valid,
    input  logic     i_ent_ready,
    output t_entry   o_ent
);

    t_entry               r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wp, n_wp;
    logic [QPTR_BITS-1:0] r_rp, n_rp;
    logic [QPTR_BITS:0]   r_cnt, n_cnt;

    t_entry w_ent;
    logic   w_keep;
    logic   w_push;
    logic   w_pop;

    always_comb begin
        w_ent.node  = i_data.node;
        w_ent.peer  = i_data.peer_node;
        w_ent.value = i_data.entry_value;
        w_ent.last  = i_data.last_in_route;
        w_ent.op    = OP_NODE;
        w_keep      = 1'b1;
        case (i_data.command)
            CMD_DIST:   w_ent.op = OP_DIST;
            CMD_DEMAND: w_ent.op = OP_DEMAND;
            CMD_NODE:   w_ent.op = OP_NODE;
            default:    w_keep   = 1'b0;     // unused command: beat taken, dropped
        endcase
    end

    assign o_ready     = (r_cnt != (QPTR_BITS+1)'(QDEPTH));
    assign o_ent_valid = (r_cnt != '0);
    assign o_ent       = r_mem[r_rp];
    assign w_push      = i_valid && o_ready && w_keep;
    assign w_pop       = o_ent_valid && i_ent_ready;

    always_comb begin
        n_wp  = w_push ? r_wp + QPTR_BITS'(1) : r_wp;
        n_rp  = w_pop  ? r_rp + QPTR_BITS'(1) : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + (QPTR_BITS+1)'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_ent;
        end
    end

endmodule

/* hdl/rcce_back.sv */
`timescale 1ns / 1ps

module rcce_back import rcce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ent_valid,
    output logic                 o_ent_ready,
    input  t_entry               i_ent,
    input  logic [LOAD_BITS-1:0] i_capacity,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output t_job                 o_job
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_LAST = 4'b0100,
        B_HAND = 4'b1000
    } t_bstate;

    logic [DIST_BITS-1:0] r_dist_mem [2**(2*NODE_BITS)];
    logic [DEM_BITS-1:0]  r_dem_mem  [2**NODE_BITS];
    logic [DIST_BITS-1:0] r_dist_q;
    logic [DEM_BITS-1:0]  r_dem_q;

    t_bstate              r_state, n_state;
    t_entry               r_cur, n_cur;
    logic [NODE_BITS-1:0] r_prev, n_prev;
    logic [SUM_BITS-1:0]  r_cost, n_cost;
    logic [LOAD_BITS-1:0] r_load, n_load;
    logic [SUM_BITS-1:0]  r_excess, n_excess;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_segb, n_segb;
    logic [POS_BITS-1:0]  r_vb, n_vb;
    logic [POS_BITS-1:0]  r_vf, n_vf;

    logic [2*NODE_BITS-1:0] w_dist_ra;
    logic                   w_take;
    logic                   w_dist_we;
    logic                   w_dem_we;
    logic                   w_is_depot;
    logic [LOAD_BITS-1:0]   w_load_sum;
    logic [LOAD_BITS-1:0]   w_close_load;
    logic [POS_BITS-1:0]    w_fin;
    logic [SUM_BITS-1:0]    w_dist_ext;

    assign o_ent_ready = (r_state == B_IDLE);
    assign w_take      = i_ent_valid && o_ent_ready;
    assign w_dist_we   = w_take && (i_ent.op == OP_DIST);
    assign w_dem_we    = w_take && (i_ent.op == OP_DEMAND);

    // read from previous node on issue; depot leg of the final node in READ
    assign w_dist_ra = (r_state == B_READ) ? {r_cur.node, DEPOT} : {r_prev, i_ent.node};

    always_ff @(posedge i_clk) begin
        if (w_dist_we) begin
            r_dist_mem[{i_ent.node, i_ent.peer}] <= i_ent.value[DIST_BITS-1:0];
        end
        r_dist_q <= r_dist_mem[w_dist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_dem_we) begin
            r_dem_mem[i_ent.node] <= i_ent.value[DEM_BITS-1:0];
        end
        r_dem_q <= r_dem_mem[i_ent.node];
    end

    assign w_dist_ext   = {{(SUM_BITS-DIST_BITS){1'b0}}, r_dist_q};
    assign w_is_depot   = (r_cur.node == DEPOT);
    assign w_load_sum   = sat_add24(r_load, r_dem_q);
    assign w_close_load = w_is_depot ? r_load : w_load_sum;
    assign w_fin        = r_cur.last ? next_pos(r_pos) : r_pos;

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_cost   = r_cost;
        n_load   = r_load;
        n_excess = r_excess;
        n_pos    = r_pos;
        n_segb   = r_segb;
        n_vb     = r_vb;
        n_vf     = r_vf;
        case (r_state)
            B_IDLE: begin
                if (w_take && i_ent.op == OP_NODE) begin
                    n_cur   = i_ent;
                    n_prev  = i_ent.node;
                    n_state = B_READ;
                end
            end
            B_READ: begin
                n_cost = sat_add32(r_cost, w_dist_ext);
                if (w_is_depot || r_cur.last) begin
                    if (w_close_load > i_capacity) begin
                        n_excess = sat_add32(r_excess,
                            {{(SUM_BITS-LOAD_BITS){1'b0}}, w_close_load - i_capacity});
                        n_vb = r_segb;
                        n_vf = w_fin;
                    end
                    n_load = '0;
                    n_segb = next_pos(r_pos);
                end else begin
                    n_load = w_load_sum;
                end
                n_pos   = next_pos(r_pos);
                n_state = r_cur.last ? B_LAST : B_IDLE;
            end
            B_LAST: begin
                n_cost  = sat_add32(r_cost, w_dist_ext);
                n_state = B_HAND;
            end
            B_HAND: begin
                if (i_job_ready) begin
                    n_prev   = DEPOT;
                    n_cost   = '0;
                    n_load   = '0;
                    n_excess = '0;
                    n_pos    = '0;
                    n_segb   = '0;
                    n_vb     = '0;
                    n_vf     = '0;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_prev   <= DEPOT;
            r_cost   <= '0;
            r_load   <= '0;
            r_excess <= '0;
            r_pos    <= '0;
            r_segb   <= '0;
            r_vb     <= '0;
            r_vf     <= '0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_cost   <= n_cost;
            r_load   <= n_load;
            r_excess <= n_excess;
            r_pos    <= n_pos;
            r_segb   <= n_segb;
            r_vb     <= n_vb;
            r_vf     <= n_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    assign o_job_valid   = (r_state == B_HAND);
    assign o_job.cost    = r_cost;
    assign o_job.excess  = r_excess;
    assign o_job.vbegin  = r_vb;
    assign o_job.vfinish = r_vf;

endmodule

/* hdl/rcce_div.sv */
`timescale 1ns / 1ps

module rcce_div import rcce_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  t_job                i_job,
    input  logic [WGT_BITS-1:0] i_weight,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_item           o_data
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MUL  = 5'b00010,
        D_SUM  = 5'b00100,
        D_DIV  = 5'b01000,
        D_OUT  = 5'b10000
    } t_dstate;

    t_dstate              r_state, n_state;
    t_job                 r_job;
    logic [PROD_BITS-1:0] r_prod;
    logic [DEN_BITS-1:0]  r_den;
    logic [DEN_BITS-1:0]  r_rem;
    logic [FIT_BITS-1:0]  r_quo;
    logic [FIT_BITS-1:0]  r_fit;
    logic [CNT_BITS-1:0]  r_cnt;

    logic [PROD_BITS-1:0] w_prod;
    logic [DEN_BITS:0]    w_trial;
    logic [DEN_BITS:0]    w_diff;
    logic                 w_ge;

    assign w_prod  = PROD_BITS'(r_job.excess) * PROD_BITS'(i_weight);
    // restoring step: shift in next dividend bit of 2^24, subtract if it fits
    assign w_trial = {r_rem, FIT_ONE[r_cnt]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign o_job_ready = (r_state == D_IDLE);
    assign o_valid     = (r_state == D_OUT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_job_valid) n_state = D_MUL;
            D_MUL:   n_state = D_SUM;
            D_SUM:   n_state = D_DIV;
            D_DIV:   if (r_cnt == '0) n_state = D_OUT;
            D_OUT:   if (i_ready) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_job_valid) r_job <= i_job;
            end
            D_MUL: begin
                r_prod <= w_prod;
            end
            D_SUM: begin
                r_den <= {{(DEN_BITS-SUM_BITS){1'b0}}, r_job.cost}
                       + {1'b0, r_prod[PROD_BITS-1:8]};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNT_BITS'(FIT_BITS - 1);
            end
            D_DIV: begin
                r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
                r_quo <= {r_quo[FIT_BITS-2:0], w_ge};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    r_fit <= (r_den == '0) ? FIT_ONE : {r_quo[FIT_BITS-2:0], w_ge};
                end
            end
            default: ;
        endcase
    end

    assign o_data.tour_cost       = r_job.cost;
    assign o_data.overload_total  = r_job.excess;
    assign o_data.is_feasible     = (r_job.excess == '0);
    assign o_data.fitness_score   = r_fit;
    assign o_data.overload_begin  = r_job.vbegin;
    assign o_data.overload_finish = r_job.vfinish;

endmodule

/* hdl/route_cost_capacity_evaluator.sv */
`timescale 1ns / 1ps
// Table write: written at the edge the back unit takes it from the queue.
// Route node: table read as the back unit takes the beat, then accumulate; next beat after that.
// Final node: back unit steps READ, LAST (depot leg), then HAND to pass the tour on; the
// divider (MUL, SUM setup, then 25 restoring steps) takes a new tour only once OUT is taken.
// A 4-entry queue keeps taking beats, until full, while the divider works or a result waits.
// Sync active-low reset: tour state and queue cleared, capacity 2^24-1, weight 1.0, tables unset.

module route_cost_capacity_evaluator import rcce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CIDX_BITS-1:0]  i_cfg_index,
    input  logic [CDATA_BITS-1:0] i_cfg_data
);

    logic [LOAD_BITS-1:0] r_capacity;
    logic [WGT_BITS-1:0]  r_weight;

    logic   w_ent_valid;
    logic   w_ent_ready;
    t_entry w_ent;
    logic   w_job_valid;
    logic   w_job_ready;
    t_job   w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_weight   <= WGT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CAPACITY: r_capacity <= i_cfg_data[LOAD_BITS-1:0];
                REG_WEIGHT:   r_weight   <= i_cfg_data[WGT_BITS-1:0];
                default: ;
            endcase
        end
    end

    rcce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_ent_valid (w_ent_valid),
        .i_ent_ready (w_ent_ready),
        .o_ent       (w_ent)
    );

    rcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_valid (w_ent_valid),
        .o_ent_ready (w_ent_ready),
        .i_ent       (w_ent),
        .i_capacity  (r_capacity),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    rcce_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .i_weight    (r_weight),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
